/* rtl/core/awt_pkg.sv */
// Package for the ASCII word tokenizer: character constants, saturation
// limit and the state and result records shared by the step logic and top.
// No dependencies.
`default_nettype none

package awt_pkg;

    localparam int unsigned MaxTokenBytes = 65536;
    localparam int unsigned HeldWidth     = 16;
    localparam int unsigned HeldCapInt    =
        (MaxTokenBytes - 1 < 65535) ? (MaxTokenBytes - 1) : 65535;
    localparam logic [HeldWidth-1:0] HELD_CAP = HeldWidth'(HeldCapInt);

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_APOS    = 8'h27;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    typedef struct packed {
        logic                 inside_token;
        logic [HeldWidth-1:0] held_apostrophes;
    } awt_state_t;

    typedef struct packed {
        logic                 byte_valid;
        logic [7:0]           token_byte;
        logic [HeldWidth-1:0] apostrophes_before;
        logic                 token_start;
        logic                 token_end;
    } awt_result_t;

endpackage

`default_nettype wire

/* rtl/core/ascii_word_tokenizer.sv */
// Top level of the ASCII word tokenizer: input register, step logic, state
// and result register with stream handshakes. Depends on awt_pkg, awt_step.
`default_nettype none

// Streams text one byte per beat and yields at most one result beat per
// input beat: a lower-cased letter or digit with its held apostrophe count
// and start flag, or a bare end-of-token marker. Throughput is one byte per
// cycle while the output is not stalled; each byte passes the input register,
// then the result register. The tokenizer state is updated when a byte leaves
// the input register, so back-to-back bytes see each other's effect.
// Separators and bytes with no result consume no output beat.
module ascii_word_tokenizer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
    input  wire logic        s_tlast,   // text_last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] token_byte, [23:8] apostrophes_before
    output logic [1:0]       m_tuser,   // [0] byte_valid, [1] token_start
    output logic             m_tlast    // token_end
);
    import awt_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    awt_state_t  state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    awt_result_t out_reg;

    awt_state_t  step_state;
    awt_result_t step_result;
    logic        step_emit;
    logic        out_free;
    logic        advance;
    logic        accept;

    awt_step u_step (
        .text_byte (in_byte_reg),
        .text_last (in_last_reg),
        .state_cur (state_reg),
        .state_nxt (step_state),
        .result    (step_result),
        .emit      (step_emit)
    );

    always_comb begin
        out_free = !out_valid_reg || m_tready;
        advance  = in_valid_reg && out_free;
        s_tready = !in_valid_reg || out_free;
        accept   = s_tvalid && s_tready;

        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        state_next = advance ? step_state : state_reg;

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = step_emit;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && step_emit) begin
            out_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.apostrophes_before, out_reg.token_byte};
    assign m_tuser  = {out_reg.token_start, out_reg.byte_valid};
    assign m_tlast  = out_reg.token_end;

    a_marker_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && !m_tuser[1] && m_tdata == '0)
        else $error("end marker carries data");

    a_held_needs_token: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.held_apostrophes != '0 |-> state_reg.inside_token)
        else $error("apostrophes held outside a token");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_byte_reg)
        && $stable(state_reg))
        else $error("input register changed under stall");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last_reg |=> state_reg == '0)
        else $error("state not cleared after last byte");

endmodule

`default_nettype wire

/* rtl/core/awt_step.sv */
// Per-byte step logic of the ASCII word tokenizer: case fold, classify,
// result and next tokenizer state. Depends on awt_pkg.
`default_nettype none

module awt_step (
    input  wire logic [7:0]          text_byte,
    input  wire logic                text_last,
    input  wire awt_pkg::awt_state_t state_cur,
    output awt_pkg::awt_state_t      state_nxt,
    output awt_pkg::awt_result_t     result,
    output logic                     emit
);
    import awt_pkg::*;

    logic [7:0] folded;
    logic       is_word;
    logic       is_apos;

    always_comb begin
        folded = text_byte;
        if (text_byte >= CHAR_UPPER_A && text_byte <= CHAR_UPPER_Z) begin
            folded = text_byte + CASE_OFFSET;
        end
        is_word = (folded >= CHAR_LOWER_A && folded <= CHAR_LOWER_Z)
               || (folded >= CHAR_ZERO && folded <= CHAR_NINE);
        is_apos = (folded == CHAR_APOS);
    end

    always_comb begin
        state_nxt = state_cur;
        result    = '0;
        emit      = 1'b0;
        priority if (is_word) begin
            result.byte_valid         = 1'b1;
            result.token_byte         = folded;
            result.apostrophes_before = state_cur.held_apostrophes;
            result.token_start        = !state_cur.inside_token;
            result.token_end          = text_last;
            emit                      = 1'b1;
            state_nxt.inside_token     = 1'b1;
            state_nxt.held_apostrophes = '0;
        end else if (is_apos) begin
            if (state_cur.inside_token && state_cur.held_apostrophes < HELD_CAP) begin
                state_nxt.held_apostrophes = state_cur.held_apostrophes + 1'b1;
            end
            if (text_last && state_cur.inside_token) begin
                result.token_end = 1'b1;
                emit             = 1'b1;
            end
        end else begin
            if (state_cur.inside_token) begin
                result.token_end = 1'b1;
                emit             = 1'b1;
            end
            state_nxt = '0;
        end
        if (text_last) begin
            state_nxt = '0;
        end
    end

endmodule

`default_nettype wire
